@@ sv/psamp_pkg.sv @@
// Shared constants and types for the partial shuffle sampler.
package psamp_pkg;

  localparam int TABLE_DEPTH   = 1048576;
  localparam int VALUE_BITS    = 20;
  localparam int ADDR_BITS     = $clog2(TABLE_DEPTH);
  localparam int REG_BITS      = 20;
  localparam int RAND_BITS     = 32;
  localparam int RAND_CNT_BITS = $clog2(RAND_BITS);
  localparam int CFG_IDX_BITS  = 1;

  // Largest usable draw position: top table entry, clipped to register width
  localparam longint LIM_MAX_INT =
    ((TABLE_DEPTH - 1) < ((2 ** REG_BITS) - 1)) ? (TABLE_DEPTH - 1) : ((2 ** REG_BITS) - 1);
  localparam logic [REG_BITS-1:0] LIM_MAX = REG_BITS'(LIM_MAX_INT);

  localparam logic [REG_BITS-1:0] RANGE_MAX_RST    = REG_BITS'(1000000);
  localparam logic [REG_BITS-1:0] SAMPLE_COUNT_RST = REG_BITS'(10);

  localparam logic [CFG_IDX_BITS-1:0] CFG_RANGE_MAX    = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_SAMPLE_COUNT = CFG_IDX_BITS'(1);

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DRAW  = 1'b1;

  typedef struct packed {
    logic                 start;
    logic [RAND_BITS-1:0] dividend;
    logic [REG_BITS-1:0]  divisor;
  } rem_req_t;

  typedef struct packed {
    logic                done;
    logic [REG_BITS-1:0] rem;
  } rem_rsp_t;

endpackage

@@ sv/psamp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module psamp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/psamp_rem.sv @@
// Bit-serial restoring remainder unit: one dividend bit per cycle.
module psamp_rem (
  input  logic                clk,
  input  logic                rst_n,
  input  psamp_pkg::rem_req_t req,
  output psamp_pkg::rem_rsp_t rsp
);

  logic                                active_r, active_nxt;
  logic                                done_r, done_nxt;
  logic [psamp_pkg::RAND_CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [psamp_pkg::RAND_BITS-1:0]     dvd_r, dvd_nxt;
  logic [psamp_pkg::REG_BITS-1:0]      dvs_r, dvs_nxt;
  logic [psamp_pkg::REG_BITS-1:0]      rem_r, rem_nxt;
  logic [psamp_pkg::REG_BITS:0]        trial;

  always_comb begin
    active_nxt = active_r;
    done_nxt   = 1'b0;
    cnt_nxt    = cnt_r;
    dvd_nxt    = dvd_r;
    dvs_nxt    = dvs_r;
    rem_nxt    = rem_r;
    trial      = {rem_r, dvd_r[psamp_pkg::RAND_BITS-1]};
    if (req.start) begin
      active_nxt = 1'b1;
      cnt_nxt    = '0;
      dvd_nxt    = req.dividend;
      dvs_nxt    = req.divisor;
      rem_nxt    = '0;
    end else if (active_r) begin
      // partial remainder stays below divisor, so trial < 2 * divisor
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = psamp_pkg::REG_BITS'(trial - {1'b0, dvs_r});
      end else begin
        rem_nxt = trial[psamp_pkg::REG_BITS-1:0];
      end
      dvd_nxt = {dvd_r[psamp_pkg::RAND_BITS-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == psamp_pkg::RAND_CNT_BITS'(psamp_pkg::RAND_BITS - 1)) begin
        active_nxt = 1'b0;
        done_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      active_r <= active_nxt;
      done_r   <= done_nxt;
      cnt_r    <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

@@ sv/partial_shuffle_sampler_top.sv @@
// Top level of the partial shuffle sampler: sequencer, registers and output stage.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------
//  in_     | in        | in_valid / in_stall   | in_cmd, in_rand_word
//  out_    | out       | out_valid / out_stall | out_value, out_last, out_exhausted
//  cfg_    | in        | cfg_we (no wait)      | cfg_index, cfg_data
//
// A draw transaction runs the bound check, the 32-step bit-serial remainder unit,
//   two RAM reads and two writes before its result reaches the output register.
// An exhausted draw goes from the bound check straight to the hand-off state. A start
//   runs the identity load, which sweeps the whole permutation RAM, one entry per cycle.
// Reset: no clearing pass; the table stays unloaded and draws answer exhausted
//   until the first start. Registers return to range 1000000, sample count 10.
// Stalls: one item at a time; a finished result waits in the output register
//   and holds the sequencer in its hand-off state until taken.
module partial_shuffle_sampler_top (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_cmd,
  input  logic [psamp_pkg::RAND_BITS-1:0]     in_rand_word,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [psamp_pkg::REG_BITS-1:0]      out_value,
  output logic                                out_last,
  output logic                                out_exhausted,
  // configuration port
  input  logic                                cfg_we,
  input  logic [psamp_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [psamp_pkg::REG_BITS-1:0]      cfg_data
);

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;  // waiting for a transaction
  localparam logic [2:0] ST_FILL = 3'd1;  // identity sweep of the table
  localparam logic [2:0] ST_CHK  = 3'd2;  // bound check, start remainder
  localparam logic [2:0] ST_DIV  = 3'd3;  // remainder unit busy
  localparam logic [2:0] ST_RDJ  = 3'd4;  // entry i arrives, read entry j
  localparam logic [2:0] ST_WRI  = 3'd5;  // entry j arrives, write it at i
  localparam logic [2:0] ST_WRJ  = 3'd6;  // write old entry i at j
  localparam logic [2:0] ST_PUT  = 3'd7;  // hand result to output register

  logic [2:0]                           state_r, state_nxt;
  logic [psamp_pkg::REG_BITS-1:0]       range_max_r, range_max_nxt;
  logic [psamp_pkg::REG_BITS-1:0]       sample_count_r, sample_count_nxt;
  logic [psamp_pkg::REG_BITS-1:0]       count_r, count_nxt;
  logic                                 ready_r, ready_nxt;
  logic [psamp_pkg::ADDR_BITS-1:0]      fill_r, fill_nxt;
  logic [psamp_pkg::RAND_BITS-1:0]      rand_r, rand_nxt;
  logic [psamp_pkg::REG_BITS-1:0]       i_r, i_nxt;
  logic [psamp_pkg::REG_BITS-1:0]       j_r, j_nxt;
  logic [psamp_pkg::REG_BITS-1:0]       bound_r, bound_nxt;
  logic [psamp_pkg::VALUE_BITS-1:0]     a_r, a_nxt;
  logic [psamp_pkg::VALUE_BITS-1:0]     b_r, b_nxt;
  logic                                 res_last_r, res_last_nxt;
  logic                                 res_exh_r, res_exh_nxt;
  logic                                 out_valid_r, out_valid_nxt;
  logic [psamp_pkg::REG_BITS-1:0]       out_value_r, out_value_nxt;
  logic                                 out_last_r, out_last_nxt;
  logic                                 out_exh_r, out_exh_nxt;

  logic [psamp_pkg::REG_BITS-1:0]       lim;
  logic [psamp_pkg::REG_BITS-1:0]       bound;
  logic                                 in_take;
  logic                                 out_free;

  logic                                 ram_we;
  logic [psamp_pkg::ADDR_BITS-1:0]      ram_waddr;
  logic [psamp_pkg::VALUE_BITS-1:0]     ram_wdata;
  logic [psamp_pkg::ADDR_BITS-1:0]      ram_raddr;
  logic [psamp_pkg::VALUE_BITS-1:0]     ram_rdata;

  psamp_pkg::rem_req_t                  rem_req;
  psamp_pkg::rem_rsp_t                  rem_rsp;

  psamp_ram #(
    .WIDTH (psamp_pkg::VALUE_BITS),
    .DEPTH (psamp_pkg::TABLE_DEPTH)
  ) u_perm_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  psamp_rem u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rem_req),
    .rsp   (rem_rsp)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  // output register can take a new result this cycle
  assign out_free = !out_valid_r || !out_stall;

  // effective range and sample bound from the live registers
  always_comb begin
    lim   = (range_max_r > psamp_pkg::LIM_MAX) ? psamp_pkg::LIM_MAX : range_max_r;
    bound = (sample_count_r < lim) ? sample_count_r : lim;
  end

  always_comb begin
    state_nxt        = state_r;
    range_max_nxt    = range_max_r;
    sample_count_nxt = sample_count_r;
    count_nxt        = count_r;
    ready_nxt        = ready_r;
    fill_nxt         = fill_r;
    rand_nxt         = rand_r;
    i_nxt            = i_r;
    j_nxt            = j_r;
    bound_nxt        = bound_r;
    a_nxt            = a_r;
    b_nxt            = b_r;
    res_last_nxt     = res_last_r;
    res_exh_nxt      = res_exh_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_value_nxt    = out_value_r;
    out_last_nxt     = out_last_r;
    out_exh_nxt      = out_exh_r;
    ram_we           = 1'b0;
    ram_waddr        = psamp_pkg::ADDR_BITS'(i_r);
    ram_wdata        = b_r;
    ram_raddr        = psamp_pkg::ADDR_BITS'(i_r);
    rem_req.start    = 1'b0;
    rem_req.dividend = rand_r;
    rem_req.divisor  = lim - count_r;  // span = lim - i + 1

    if (cfg_we) begin
      unique case (cfg_index)
        psamp_pkg::CFG_RANGE_MAX:    range_max_nxt    = cfg_data;
        psamp_pkg::CFG_SAMPLE_COUNT: sample_count_nxt = cfg_data;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          rand_nxt = in_rand_word;
          fill_nxt = '0;
          state_nxt = (in_cmd == psamp_pkg::CMD_START) ? ST_FILL : ST_CHK;
        end
      end
      ST_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = fill_r;
        ram_wdata = psamp_pkg::VALUE_BITS'(fill_r);
        fill_nxt  = fill_r + 1'b1;
        if (fill_r == psamp_pkg::ADDR_BITS'(psamp_pkg::TABLE_DEPTH - 1)) begin
          count_nxt = '0;
          ready_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_CHK: begin
        bound_nxt = bound;
        if (!ready_r || (count_r >= bound)) begin
          b_nxt        = '0;
          res_last_nxt = 1'b0;
          res_exh_nxt  = 1'b1;
          state_nxt    = ST_PUT;
        end else begin
          i_nxt         = count_r + 1'b1;
          rem_req.start = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        // read of entry i is issued on the finishing cycle
        if (rem_rsp.done) begin
          j_nxt     = i_r + rem_rsp.rem;
          state_nxt = ST_RDJ;
        end
      end
      ST_RDJ: begin
        ram_raddr = psamp_pkg::ADDR_BITS'(j_r);
        a_nxt     = ram_rdata;
        state_nxt = ST_WRI;
      end
      ST_WRI: begin
        ram_we    = 1'b1;
        ram_waddr = psamp_pkg::ADDR_BITS'(i_r);
        ram_wdata = ram_rdata;
        b_nxt     = ram_rdata;
        state_nxt = ST_WRJ;
      end
      ST_WRJ: begin
        ram_we       = 1'b1;
        ram_waddr    = psamp_pkg::ADDR_BITS'(j_r);
        ram_wdata    = a_r;
        count_nxt    = i_r;
        res_last_nxt = (i_r == bound_r);
        res_exh_nxt  = 1'b0;
        state_nxt    = ST_PUT;
      end
      ST_PUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = psamp_pkg::REG_BITS'(b_r);
          out_last_nxt  = res_last_r;
          out_exh_nxt   = res_exh_r;
          state_nxt     = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      range_max_r    <= psamp_pkg::RANGE_MAX_RST;
      sample_count_r <= psamp_pkg::SAMPLE_COUNT_RST;
      count_r        <= '0;
      ready_r        <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      range_max_r    <= range_max_nxt;
      sample_count_r <= sample_count_nxt;
      count_r        <= count_nxt;
      ready_r        <= ready_nxt;
      out_valid_r    <= out_valid_nxt;
    end
    fill_r      <= fill_nxt;
    rand_r      <= rand_nxt;
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    bound_r     <= bound_nxt;
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    res_last_r  <= res_last_nxt;
    res_exh_r   <= res_exh_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
    out_exh_r   <= out_exh_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_value     = out_value_r;
  assign out_last      = out_last_r;
  assign out_exhausted = out_exh_r;

  // a new result only ever comes from the hand-off state
  a_put_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_PUT))
    else $error("result loaded outside hand-off state");

  // an exhausted transaction carries neither a value nor the last mark
  a_exh_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_exh_r) |-> (out_value_r == '0 && !out_last_r))
    else $error("exhausted result with value or last set");

  // remainder unit finishes only while the sequencer waits for it
  a_rem_done: assert property (@(posedge clk) disable iff (!rst_n)
    rem_rsp.done |-> (state_r == ST_DIV))
    else $error("remainder done outside divide state");

  // the draw count never passes the top table position
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= psamp_pkg::LIM_MAX)
    else $error("draw count beyond table");

  // a draw's swap writes follow straight on from the remainder result
  a_swap_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WRJ) |-> ($past(state_r) == ST_WRI && $past(state_r, 2) == ST_RDJ))
    else $error("swap sequence broken");

endmodule
